[src/h264aus_pkg.sv]
package h264aus_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int INDEX_BITS = 16;
	localparam int ADDR_BITS = 48;
	localparam int LEN_BITS = 32;
	localparam int IDX_OUT_BITS = 16;
	localparam int WIN_LEN = 9;
	localparam int FILL_BITS = $clog2(WIN_LEN + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 64;

	// NAL unit types
	localparam logic [4:0] NAL_SLICE = 5'd1;
	localparam logic [4:0] NAL_IDR = 5'd5;
	localparam logic [4:0] NAL_SEI = 5'd6;
	localparam logic [4:0] NAL_SPS = 5'd7;
	localparam logic [4:0] NAL_PPS = 5'd8;
	localparam logic [4:0] NAL_SUBSET_SPS = 5'd15;
	localparam logic [4:0] NAL_SLICE_EXT = 5'd20;
	// top bit of the first ue(v) byte: first_mb_in_slice == 0
	localparam int FIRST_MB_BIT = 7;

	typedef logic [7:0] octet_t;
	typedef logic [OFFSET_BITS-1:0] pos_t;
	typedef logic [INDEX_BITS-1:0] count_t;

	typedef struct packed {
		pos_t begin_pos;
		logic [LEN_BITS-1:0] len;
		logic [IDX_OUT_BITS-1:0] idx;
		logic found;
	} frame_t;

	// all frames produced by one input byte
	typedef struct packed {
		logic has_mid;
		frame_t mid;
		logic has_fin;
		frame_t fin;
	} step_t;

	function automatic logic [LEN_BITS-1:0] sat_len(input pos_t l);
		logic [63:0] wide;
		wide = 64'(l);
		if (wide > 64'h0000_0000_FFFF_FFFF) begin
			return '1;
		end
		return wide[LEN_BITS-1:0];
	endfunction

	function automatic count_t sat_inc(input count_t c);
		if (c == '1) begin
			return c;
		end
		return c + count_t'(1);
	endfunction

	function automatic logic [IDX_OUT_BITS-1:0] idx_out(input count_t c);
		return IDX_OUT_BITS'(c);
	endfunction

endpackage

[src/h264aus_front.sv]
module h264aus_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 data_valid,
	output logic                 data_ready,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic                 q_full,
	output logic                 push,
	output h264aus_pkg::step_t   push_data
);
	import h264aus_pkg::*;

	octet_t win_q [WIN_LEN];
	octet_t win_n [WIN_LEN];
	logic [FILL_BITS-1:0] fill_q, fill_n;
	pos_t pos_q, seg_q, esf_q;
	logic slice_q;
	count_t cnt_q;

	logic acc, full_win, start, first, endc, close, open;
	logic [4:0] typ;
	pos_t q, rel, from, seg1, esf2, pos1;
	logic slice1, slice2;
	count_t cnt1;

	assign data_ready = !q_full;
	assign acc = data_valid && data_ready;

	always_comb begin
		for (int i = 0; i < WIN_LEN - 1; i++) begin
			win_n[i] = win_q[i+1];
		end
		win_n[WIN_LEN-1] = data_byte;
		fill_n = (fill_q == FILL_BITS'(WIN_LEN)) ? fill_q : fill_q + FILL_BITS'(1);
		full_win = fill_n == FILL_BITS'(WIN_LEN);

		start = win_n[0] == 8'd0 && win_n[1] == 8'd0 && win_n[2] == 8'd1;
		typ = win_n[3][4:0];
		first = start && ((((typ == NAL_IDR) || (typ == NAL_SLICE)) && win_n[4][FIRST_MB_BIT])
			|| ((typ == NAL_SLICE_EXT) && win_n[7][FIRST_MB_BIT]));
		endc = (start && (typ == NAL_SUBSET_SPS || typ == NAL_SPS || typ == NAL_PPS
			|| typ == NAL_SEI)) || first;

		// q: stream offset of the window's oldest byte
		q = pos_q - pos_t'(WIN_LEN - 1);
		rel = q - seg_q;
		from = esf_q - seg_q;
		close = full_win && slice_q && (rel >= from) && endc;

		seg1 = close ? q : seg_q;
		slice1 = close ? 1'b0 : slice_q;
		cnt1 = close ? sat_inc(cnt_q) : cnt_q;

		open = full_win && !slice1 && first;
		slice2 = slice1 || open;
		esf2 = open ? q + pos_t'(WIN_LEN - 1) : esf_q;
		pos1 = pos_q + pos_t'(1);

		push = acc && (close || last_byte);
		push_data.has_mid = close;
		push_data.mid.begin_pos = seg_q;
		push_data.mid.len = sat_len(rel);
		push_data.mid.idx = idx_out(cnt_q);
		push_data.mid.found = 1'b1;
		push_data.has_fin = last_byte;
		push_data.fin.begin_pos = seg1;
		push_data.fin.len = sat_len(pos1 - seg1);
		push_data.fin.idx = idx_out(cnt1);
		push_data.fin.found = slice2;
	end

	// window contents only count once fill reaches WIN_LEN, so no reset
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= win_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q <= '0;
			seg_q <= '0;
			esf_q <= '0;
			slice_q <= 1'b0;
			cnt_q <= '0;
		end else if (acc) begin
			if (last_byte) begin
				fill_q <= '0;
				pos_q <= '0;
				seg_q <= '0;
				esf_q <= '0;
				slice_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				fill_q <= fill_n;
				pos_q <= pos1;
				seg_q <= seg1;
				esf_q <= esf2;
				slice_q <= slice2;
				cnt_q <= cnt1;
			end
		end
	end

endmodule

[src/h264aus_fifo.sv]
module h264aus_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  h264aus_pkg::step_t wdata,
	output logic               full,
	input  logic               pop,
	output h264aus_pkg::step_t rdata,
	output logic               empty
);
	import h264aus_pkg::*;

	step_t mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QCNT_BITS-1:0] cnt_q;

	assign full = cnt_q == QCNT_BITS'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_BITS'(1);
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

[src/h264aus_back.sv]
module h264aus_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [47:0]          base_address,
	input  logic                 empty,
	input  h264aus_pkg::step_t   head,
	output logic                 pop,
	output logic                 frame_valid,
	input  logic                 frame_ready,
	output logic [47:0]          frame_address,
	output logic [31:0]          frame_length,
	output logic [15:0]          frame_index,
	output logic                 start_found,
	output logic                 final_frame
);
	import h264aus_pkg::*;

	logic phase_q, valid_q;
	logic load, take_mid;
	frame_t sel;
	logic [ADDR_BITS-1:0] addr_q;
	logic [LEN_BITS-1:0] len_q;
	logic [IDX_OUT_BITS-1:0] idx_q;
	logic found_q, fin_q;

	assign load = !empty && (!valid_q || frame_ready);
	// phase_q set: the mid-stream frame of the head transaction is already out
	assign take_mid = head.has_mid && !phase_q;
	assign sel = take_mid ? head.mid : head.fin;
	assign pop = load && (!take_mid || !head.has_fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= take_mid && head.has_fin;
				valid_q <= 1'b1;
			end else if (frame_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			addr_q <= base_address + ADDR_BITS'(sel.begin_pos);
			len_q <= sel.len;
			idx_q <= sel.idx;
			found_q <= sel.found;
			fin_q <= !take_mid;
		end
	end

	assign frame_valid = valid_q;
	assign frame_address = addr_q;
	assign frame_length = len_q;
	assign frame_index = idx_q;
	assign start_found = found_q;
	assign final_frame = fin_q;

	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (!empty && head.has_mid && head.has_fin))
		else $error("second-frame phase without a two-frame head");

endmodule

[src/h264_access_unit_splitter_core.sv]
// H.264 Annex B access-unit splitter. Takes one stream byte per cycle and reports one
// frame (address, length, index, start flag, final flag) per output transaction. A start
// code is seen once the eight bytes after its first byte have arrived, so frames close
// up to nine bytes after their end; last_byte flushes the remainder as the final frame
// and restarts offsets and frame index at zero. The front end classifies each byte
// combinationally and writes any frames it produced into a four-entry queue; the output
// side drains the queue at one frame per cycle while frame_ready is high, through a
// registered output. A byte that both closes a frame and ends the stream yields two frames.
// Input stalls only when the queue is full. base_address is a 48-bit register in the low
// bits of the 64-bit word at offset 0 and must be written while no bytes are in flight.
module h264_access_unit_splitter_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [h264aus_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [h264aus_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [h264aus_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                    pready,
	input  logic                                    data_valid,
	output logic                                    data_ready,
	input  logic [7:0]                              data_byte,
	input  logic                                    last_byte,
	output logic                                    frame_valid,
	input  logic                                    frame_ready,
	output logic [47:0]                             frame_address,
	output logic [31:0]                             frame_length,
	output logic [15:0]                             frame_index,
	output logic                                    start_found,
	output logic                                    final_frame
);
	import h264aus_pkg::*;

	logic [ADDR_BITS-1:0] base_q;
	logic reg_hit;
	logic push, q_full, q_empty, pop;
	step_t push_data, head;

	assign pready = 1'b1;
	assign reg_hit = !paddr[3];
	assign prdata = reg_hit ? APB_DATA_BITS'(base_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			base_q <= pwdata[ADDR_BITS-1:0];
		end
	end

	h264aus_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	h264aus_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (q_full),
		.pop    (pop),
		.rdata  (head),
		.empty  (q_empty)
	);

	h264aus_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.base_address  (base_q),
		.empty         (q_empty),
		.head          (head),
		.pop           (pop),
		.frame_valid   (frame_valid),
		.frame_ready   (frame_ready),
		.frame_address (frame_address),
		.frame_length  (frame_length),
		.frame_index   (frame_index),
		.start_found   (start_found),
		.final_frame   (final_frame)
	);

endmodule

[verif/tb.sv]
module tb;
	import h264aus_pkg::*;

	localparam logic [APB_ADDR_BITS-1:0] BASE_ADDR_REG = '0;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DIR_ROWS = 28;

	typedef struct packed {
		logic [ADDR_BITS-1:0] addr;
		logic [LEN_BITS-1:0] len;
		logic [IDX_OUT_BITS-1:0] idx;
		logic found;
		logic fin;
	} frame_rec_t;

	typedef struct packed {
		octet_t d;
		logic l;
		logic typed;
		frame_rec_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;
	logic data_valid;
	logic data_ready;
	logic [7:0] data_byte;
	logic last_byte;
	logic frame_valid;
	logic frame_ready;
	logic [47:0] frame_address;
	logic [31:0] frame_length;
	logic [15:0] frame_index;
	logic start_found;
	logic final_frame;

	h264_access_unit_splitter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame_address(frame_address),
		.frame_length(frame_length),
		.frame_index(frame_index),
		.start_found(start_found),
		.final_frame(final_frame)
	);

	// splitter shadow state
	octet_t win [WIN_LEN];
	int win_fill;
	pos_t byte_pos;
	pos_t seg_begin;
	logic slice_open;
	pos_t search_from;
	count_t frame_count;
	logic [ADDR_BITS-1:0] base_addr;

	frame_rec_t frames_due[$];
	octet_t stream_bytes[$];
	frame_rec_t got;
	frame_rec_t want;

	int errors;
	int stall_cycles;
	int random_items;
	int hold_off;
	logic calm;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{8'hFF, 1'b1, 1'b1, '{48'd0, 32'd1, 16'd0, 1'b0, 1'b1}},
		'{8'h00, 1'b1, 1'b1, '{48'd0, 32'd1, 16'd0, 1'b0, 1'b1}},
		// IDR first slice closed by an SPS whose start sits eight bytes from the end
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0}, '{8'h65, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0}, '{8'h11, 1'b0, 1'b0, '0},
		'{8'h22, 1'b0, 1'b0, '0}, '{8'h33, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0}, '{8'h67, 1'b0, 1'b0, '0},
		'{8'h42, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b1, 1'b0, '0},
		// extension slice, first-slice flag four bytes after the header
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h01, 1'b0, 1'b0, '0}, '{8'hF4, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b0, '0}
	};

	function automatic void clear_stream();
		foreach (win[i]) win[i] = '0;
		win_fill = 0;
		byte_pos = '0;
		seg_begin = '0;
		slice_open = 1'b0;
		search_from = '0;
		frame_count = '0;
	endfunction

	function automatic logic start_code();
		return win[0] == 8'h00 && win[1] == 8'h00 && win[2] == 8'h01;
	endfunction

	function automatic logic opens_frame();
		logic [4:0] t;
		t = win[3][4:0];
		if (!start_code()) return 1'b0;
		if ((t == NAL_IDR || t == NAL_SLICE) && win[4][FIRST_MB_BIT]) return 1'b1;
		return t == NAL_SLICE_EXT && win[7][FIRST_MB_BIT];
	endfunction

	function automatic logic closes_frame();
		logic [4:0] t;
		t = win[3][4:0];
		if (!start_code()) return 1'b0;
		if (t == NAL_SUBSET_SPS || t == NAL_SPS || t == NAL_PPS || t == NAL_SEI) return 1'b1;
		return opens_frame();
	endfunction

	function automatic void log_frame(pos_t start_p, pos_t len, logic found, logic fin);
		frame_rec_t f;
		f.addr = base_addr + ADDR_BITS'(start_p);
		f.len = LEN_BITS'(len);
		f.idx = IDX_OUT_BITS'(frame_count);
		f.found = found;
		f.fin = fin;
		frames_due.push_back(f);
		if (frame_count != '1) frame_count = frame_count + 1'b1;
	endfunction

	function automatic void track_byte(octet_t d, logic l);
		pos_t q;
		pos_t rel;
		pos_t from;
		for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i+1];
		win[WIN_LEN-1] = d;
		if (win_fill < WIN_LEN) win_fill++;
		if (win_fill == WIN_LEN) begin
			q = byte_pos - pos_t'(8);
			rel = q - seg_begin;
			from = search_from - seg_begin;
			if (slice_open && rel >= from && closes_frame()) begin
				log_frame(seg_begin, rel, 1'b1, 1'b0);
				seg_begin = q;
				slice_open = 1'b0;
			end
			if (!slice_open && opens_frame()) begin
				slice_open = 1'b1;
				search_from = q + pos_t'(8);
			end
		end
		byte_pos = byte_pos + 1'b1;
		if (l) begin
			log_frame(seg_begin, byte_pos - seg_begin, slice_open, 1'b1);
			clear_stream();
		end
	endfunction

	function automatic int idle_gap();
		int n;
		n = 0;
		if (!calm) begin
			while ($urandom_range(99) < 33) n++;
		end
		return n;
	endfunction

	function automatic void build_stream();
		int kind;
		int plen;
		logic [4:0] t;
		stream_bytes = {};
		repeat ($urandom_range(12, 1)) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				if ($urandom_range(3) == 0) stream_bytes.push_back(8'h00);
				stream_bytes.push_back(8'h00);
				stream_bytes.push_back(8'h00);
				stream_bytes.push_back(8'h01);
				case ($urandom_range(9))
					0, 1: t = NAL_SLICE;
					2, 3: t = NAL_IDR;
					4: t = NAL_SLICE_EXT;
					5: t = NAL_SPS;
					6: t = NAL_PPS;
					7: t = NAL_SEI;
					8: t = NAL_SUBSET_SPS;
					default: t = 5'($urandom);
				endcase
				stream_bytes.push_back({3'($urandom), t});
				plen = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(10);
				repeat (plen) stream_bytes.push_back(octet_t'($urandom));
			end else if (kind < 90) begin
				// zero run ended by a random byte: mostly a broken start code
				repeat ($urandom_range(4, 1)) stream_bytes.push_back(8'h00);
				stream_bytes.push_back(octet_t'($urandom));
			end else begin
				repeat ($urandom_range(12, 1)) begin
					stream_bytes.push_back($urandom_range(1) ? 8'h00 : octet_t'($urandom));
				end
			end
		end
	endfunction

	// entered and left at a falling edge
	task automatic send_byte(input octet_t d, input logic l, input logic typed,
			input frame_rec_t typed_want);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do @(posedge clk); while (!data_ready);
		track_byte(d, l);
		if (typed) begin
			void'(frames_due.pop_back());
			frames_due.push_back(typed_want);
		end
		@(negedge clk);
	endtask

	task automatic send_stream();
		build_stream();
		@(negedge clk);
		foreach (stream_bytes[i]) begin
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1, 1'b0, '0);
		end
		data_valid <= 1'b0;
		random_items += stream_bytes.size();
	endtask

	task automatic wait_idle();
		while (frames_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_base(input logic [APB_DATA_BITS-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BASE_ADDR_REG;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		base_addr = v[ADDR_BITS-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// output side: random back-pressure, always ready when calm, plus a long hold-off on request
	initial begin
		frame_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				frame_ready <= 1'b0;
				hold_off--;
			end else if (calm) begin
				frame_ready <= 1'b1;
			end else begin
				frame_ready <= ($urandom_range(99) >= 33);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && frame_valid && frame_ready) begin
			got = '{frame_address, frame_length, frame_index, start_found, final_frame};
			if (frames_due.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected frame: addr=%h len=%0d idx=%0d found=%b final=%b",
						got.addr, got.len, got.idx, got.found, got.fin);
				end
			end else begin
				want = frames_due.pop_front();
				if (got.addr !== want.addr || got.len !== want.len || got.idx !== want.idx ||
						got.found !== want.found || got.fin !== want.fin) begin
					errors++;
					if (errors <= 10) begin
						$display("frame mismatch: want addr=%h len=%0d idx=%0d found=%b final=%b",
							want.addr, want.len, want.idx, want.found, want.fin);
						$display("                 got addr=%h len=%0d idx=%0d found=%b final=%b",
							got.addr, got.len, got.idx, got.found, got.fin);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((data_valid && data_ready) || (frame_valid && frame_ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		data_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		errors = 0;
		stall_cycles = 0;
		random_items = 0;
		hold_off = 0;
		calm = 1'b0;
		base_addr = '0;
		clear_stream();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			send_byte(dir_rows[i].d, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].want);
		end
		data_valid <= 1'b0;

		phase = 1;
		while (random_items < RANDOM_ITEMS) begin
			wait_idle();
			case (phase)
				1: write_base('1);
				2: write_base('0);
				3: write_base(64'h0000_FFFF_FFFF_FF00);
				4: write_base(64'h0000_FFFF_FFFF_FFFF);
				default: write_base({$urandom, $urandom});
			endcase
			calm = (phase == 2);
			if (phase == 3) hold_off = HOLD_OFF_CYCLES;
			repeat (4) send_stream();
			phase++;
		end
		calm = 1'b0;

		wait_idle();
		if (errors == 0 && frames_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[files.f]
src/h264aus_pkg.sv
src/h264aus_front.sv
src/h264aus_fifo.sv
src/h264aus_back.sv
src/h264_access_unit_splitter_core.sv
verif/tb.sv
